// ===== sv/tnop_pkg.sv =====
// tnop_pkg: shared types, telnet codes and reply tables for the telnet option parser
// no dependencies; compiled first
package tnop_pkg;

    // longest variable name accepted, counted in sub-negotiation positions
    localparam int NAME_LIMIT = 256;
    localparam int NAME_CMP_W = 13;

    // telnet command and option codes
    localparam logic [7:0] T_IAC    = 8'd255;
    localparam logic [7:0] T_DONT   = 8'd254;
    localparam logic [7:0] T_DO     = 8'd253;
    localparam logic [7:0] T_WONT   = 8'd252;
    localparam logic [7:0] T_WILL   = 8'd251;
    localparam logic [7:0] T_SB     = 8'd250;
    localparam logic [7:0] T_AYT    = 8'd246;
    localparam logic [7:0] T_NOP    = 8'd241;
    localparam logic [7:0] T_SE     = 8'd240;
    localparam logic [7:0] OPT_ECHO = 8'd1;
    localparam logic [7:0] OPT_SGA  = 8'd3;
    localparam logic [7:0] OPT_NAWS = 8'd31;
    localparam logic [7:0] OPT_ENV  = 8'd39;
    localparam logic [7:0] ENV_IS   = 8'd0;
    localparam logic [7:0] ENV_VAL  = 8'd1;
    localparam logic [7:0] ENV_SEND = 8'd1;
    localparam logic [7:0] CH_DEL   = 8'h7f;
    localparam logic [7:0] CH_LF    = 8'd10;

    // result kinds
    localparam logic [1:0] KIND_USER = 2'd0;
    localparam logic [1:0] KIND_PEER = 2'd1;
    localparam logic [1:0] KIND_SIZE = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_BACKSPACE = 3'd0;
    localparam logic [2:0] CFG_RETURN    = 3'd1;
    localparam logic [2:0] CFG_DEF_WIDTH = 3'd2;
    localparam logic [2:0] CFG_DEF_HEIGHT = 3'd3;
    localparam logic [2:0] CFG_MAX_TERM  = 3'd4;

    // configuration reset values
    localparam logic [7:0]  RST_BACKSPACE = 8'd8;
    localparam logic [7:0]  RST_RETURN    = 8'd13;
    localparam logic [15:0] RST_DEF_WIDTH = 16'd80;
    localparam logic [15:0] RST_DEF_HEIGHT = 16'd24;
    localparam logic [15:0] RST_MAX_TERM  = 16'd255;

    // name matching progress codes
    localparam logic [2:0] NP_BAD  = 3'd5;
    localparam logic [2:0] NP_DONE = 3'd6;
    localparam logic [2:0] NP_FULL = 3'd4;

    typedef enum logic [3:0] {
        S_DATA   = 4'd0,
        S_IAC    = 4'd1,
        S_WILL   = 4'd2,
        S_DO     = 4'd3,
        S_NAWS   = 4'd4,
        S_ENV    = 4'd5,
        S_ENV_IS = 4'd6,
        S_VAR    = 4'd7,
        S_VAL    = 4'd8,
        S_ARG    = 4'd9
    } parse_state_t;

    // result sequences a single received byte can start
    typedef enum logic [2:0] {
        SEQ_USER   = 3'd0,
        SEQ_REFUSE = 3'd1,
        SEQ_AYT    = 3'd2,
        SEQ_ENV    = 3'd3,
        SEQ_SIZE   = 3'd4
    } seq_t;

    function automatic logic [2:0] seq_len(input seq_t s);
        logic [2:0] n;
        case (s)
            SEQ_REFUSE: n = 3'd3;
            SEQ_AYT:    n = 3'd7;
            SEQ_ENV:    n = 3'd6;
            default:    n = 3'd1;
        endcase
        return n;
    endfunction

    // are-you-there answer "\n[YeS]\n"
    function automatic logic [7:0] ayt_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h0a;
            3'd1:    b = 8'h5b;
            3'd2:    b = 8'h59;
            3'd3:    b = 8'h65;
            3'd4:    b = 8'h53;
            3'd5:    b = 8'h5d;
            default: b = 8'h0a;
        endcase
        return b;
    endfunction

    // IAC SB NEW-ENVIRON SEND IAC SE
    function automatic logic [7:0] env_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = T_IAC;
            3'd1:    b = T_SB;
            3'd2:    b = OPT_ENV;
            3'd3:    b = ENV_SEND;
            3'd4:    b = T_IAC;
            default: b = T_SE;
        endcase
        return b;
    endfunction

    // characters of the variable name USER
    function automatic logic [7:0] user_char(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h55;
            2'd1:    b = 8'h53;
            2'd2:    b = 8'h45;
            default: b = 8'h52;
        endcase
        return b;
    endfunction

    // small values fall back to the default, then everything is capped
    function automatic logic [15:0] clamp_size(input logic [15:0] v, input logic [15:0] floor_v,
                                               input logic [15:0] dflt, input logic [15:0] maxv);
        logic [15:0] r;
        r = (v <= floor_v) ? dflt : v;
        if (r > maxv)
            r = maxv;
        return r;
    endfunction

endpackage

// ===== sv/tnop_in_if.sv =====
// tnop_in_if: valid/ready channel carrying one received telnet byte
// depends on nothing
interface tnop_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== sv/tnop_out_if.sv =====
// tnop_out_if: valid/ready channel carrying one parser result
// depends on nothing
interface tnop_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [15:0] term_cols;
    logic [15:0] term_rows;
    logic        last;

    modport source (output valid, output kind, output out_byte, output term_cols,
                    output term_rows, output last, input ready);
    modport sink (input valid, input kind, input out_byte, input term_cols,
                  input term_rows, input last, output ready);
endinterface

// ===== sv/telnet_option_parser_unit.sv =====
// telnet_option_parser_unit: server-side telnet negotiation parser, top level
// depends on tnop_pkg, tnop_in_if, tnop_out_if
//
// usage:
//   in_ch carries one received byte per transaction; out_ch carries results
//   (user byte, byte for the peer, or window size update), last marks the
//   final result of a received byte.  a byte may cause zero to seven results.
//   configuration is written through cfg_we / cfg_index / cfg_data while idle.
// timing and throughput:
//   the parser state is updated in the accepting cycle; the first result of
//   that byte is valid in the next cycle.  while out_ch.ready stays high, a
//   byte with at most one result sustains one byte per cycle.  a byte with
//   several results occupies the result sequencer until its last result
//   leaves, and the next byte is taken in the cycle that result is handed over.
// reset:
//   state returns to plain data, counters clear, window size takes the
//   default registers' reset values, no result is pending.
// receiver stall:
//   a pending result holds; in_ch.ready drops until its last result leaves.
module telnet_option_parser_unit
    import tnop_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    tnop_in_if.sink          in_ch,
    tnop_out_if.source       out_ch,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [15:0]      cfg_data
);

    // configuration registers
    logic [7:0]  bs_code_reg;
    logic [7:0]  ret_code_reg;
    logic [15:0] def_w_reg;
    logic [15:0] def_h_reg;
    logic [15:0] max_term_reg;

    // parser state
    parse_state_t state_reg, state_next;
    logic [7:0]   sub_reg, sub_next;
    logic [7:0]   size_reg [4];
    logic [7:0]   size_next [4];
    logic [2:0]   np_reg, np_next;
    logic         vu_reg, vu_next;
    logic [15:0]  cur_w_reg, cur_w_next;
    logic [15:0]  cur_h_reg, cur_h_next;

    // result sequencer
    logic         pend_reg, pend_next;
    seq_t         seq_reg, seq_next;
    logic [2:0]   idx_reg, idx_next;
    logic [7:0]   ba_reg, ba_next;
    logic [7:0]   bb_reg, bb_next;
    logic [15:0]  cols_reg, cols_next;
    logic [15:0]  rows_reg, rows_next;

    // per-byte result descriptor
    logic         res_c;
    seq_t         seq_c;
    logic [7:0]   ba_c;
    logic [7:0]   bb_c;

    logic         in_fire;
    logic         out_fire;
    logic         out_last;
    logic [7:0]   c;
    logic [7:0]   sub_inc;
    logic [15:0]  w_dec;
    logic [15:0]  h_dec;
    logic [15:0]  w_clamped;
    logic [15:0]  h_clamped;
    logic         name_room;

    assign c         = in_ch.rx_byte;
    assign out_last  = (idx_reg == seq_len(seq_reg) - 3'd1);
    assign out_fire  = out_ch.valid && out_ch.ready;
    assign in_ch.ready = !pend_reg || (out_ch.ready && out_last);
    assign in_fire   = in_ch.valid && in_ch.ready;
    assign sub_inc   = (sub_reg == 8'd255) ? sub_reg : sub_reg + 8'd1;
    assign w_dec     = {size_reg[0], size_reg[1]};
    assign h_dec     = {size_reg[2], size_reg[3]};
    assign w_clamped = clamp_size(w_dec, 16'd1, def_w_reg, max_term_reg);
    assign h_clamped = clamp_size(h_dec, 16'd2, def_h_reg, max_term_reg);
    assign name_room = {{(NAME_CMP_W - 8){1'b0}}, sub_reg} < NAME_CMP_W'(NAME_LIMIT - 2);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bs_code_reg  <= RST_BACKSPACE;
            ret_code_reg <= RST_RETURN;
            def_w_reg    <= RST_DEF_WIDTH;
            def_h_reg    <= RST_DEF_HEIGHT;
            max_term_reg <= RST_MAX_TERM;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BACKSPACE:  bs_code_reg  <= cfg_data[7:0];
                CFG_RETURN:     ret_code_reg <= cfg_data[7:0];
                CFG_DEF_WIDTH:  def_w_reg    <= cfg_data;
                CFG_DEF_HEIGHT: def_h_reg    <= cfg_data;
                CFG_MAX_TERM:   max_term_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // parser next state and result descriptor
    always_comb
    begin
        state_next = state_reg;
        sub_next   = sub_reg;
        size_next  = size_reg;
        np_next    = np_reg;
        vu_next    = vu_reg;
        cur_w_next = cur_w_reg;
        cur_h_next = cur_h_reg;
        res_c      = 1'b0;
        seq_c      = SEQ_USER;
        ba_c       = 8'd0;
        bb_c       = 8'd0;

        case (state_reg)
            S_DATA:
            begin
                if (c == T_IAC)
                    state_next = S_IAC;
                else if (c == CH_DEL)
                begin
                    res_c = 1'b1;
                    ba_c  = bs_code_reg;
                end
                else if (c != 8'd0 && c != CH_LF && c < CH_DEL)
                begin
                    res_c = 1'b1;
                    ba_c  = c;
                end
            end
            S_IAC:
            begin
                case (c)
                    T_IAC:
                    begin
                        state_next = S_DATA;
                        res_c      = 1'b1;
                    end
                    T_AYT:
                    begin
                        state_next = S_DATA;
                        res_c      = 1'b1;
                        seq_c      = SEQ_AYT;
                    end
                    T_NOP:    state_next = S_DATA;
                    T_SB:     sub_next = sub_inc;
                    T_SE:
                    begin
                        if (sub_reg != 8'd0)
                            sub_next = sub_reg - 8'd1;
                        state_next = S_DATA;
                    end
                    T_WILL:   state_next = S_WILL;
                    T_DO:     state_next = S_DO;
                    OPT_NAWS: state_next = S_NAWS;
                    OPT_ENV:  state_next = S_ENV;
                    default:  state_next = S_ARG;
                endcase
            end
            S_WILL:
            begin
                if (c == OPT_ENV)
                begin
                    res_c = 1'b1;
                    seq_c = SEQ_ENV;
                end
                else if (c != OPT_NAWS)
                begin
                    res_c = 1'b1;
                    seq_c = SEQ_REFUSE;
                    ba_c  = c;
                    bb_c  = T_DONT;
                end
                state_next = S_DATA;
            end
            S_DO:
            begin
                if (c != OPT_SGA && c != OPT_ECHO)
                begin
                    res_c = 1'b1;
                    seq_c = SEQ_REFUSE;
                    ba_c  = c;
                    bb_c  = T_WONT;
                end
                state_next = S_DATA;
            end
            S_NAWS:
            begin
                if (sub_reg <= 8'd4)
                begin
                    for (int k = 0; k < 4; k++)
                        if (sub_reg == 8'(k + 1))
                            size_next[k] = c;
                    sub_next = sub_reg + 8'd1;
                end
                else
                begin
                    cur_w_next = w_clamped;
                    cur_h_next = h_clamped;
                    sub_next   = 8'd0;
                    state_next = S_IAC;
                    res_c      = 1'b1;
                    seq_c      = SEQ_SIZE;
                end
            end
            S_ENV:
            begin
                if (c == ENV_IS)
                    state_next = S_ENV_IS;
                sub_next     = 8'd1;
                size_next[0] = 8'd0;
                np_next      = 3'd0;
                vu_next      = 1'b0;
            end
            S_ENV_IS:
            begin
                if (c == 8'd0 || c == 8'd2 || c == 8'd3)
                begin
                    sub_next     = 8'd1;
                    size_next[0] = 8'd0;
                    np_next      = 3'd0;
                    vu_next      = 1'b0;
                    state_next   = S_VAR;
                end
                else if (c == T_IAC)
                    state_next = S_IAC;
                else
                    state_next = S_DATA;
            end
            S_VAR:
            begin
                if (c == ENV_VAL)
                begin
                    for (int k = 0; k < 4; k++)
                        if (sub_reg == 8'(k + 1))
                            size_next[k] = 8'd0;
                    sub_next   = sub_inc;
                    vu_next    = (np_reg == NP_FULL) || (np_reg == NP_DONE);
                    state_next = S_VAL;
                end
                else if (c == T_IAC)
                    state_next = S_IAC;
                else if (name_room)
                begin
                    // name byte at the old position, terminator at the new one
                    for (int k = 0; k < 4; k++)
                    begin
                        if (sub_reg == 8'(k + 1))
                            size_next[k] = c;
                        if (sub_inc == 8'(k + 1))
                            size_next[k] = 8'd0;
                    end
                    sub_next = sub_inc;
                    if (np_reg < NP_FULL)
                        np_next = (c != 8'd0 && c == user_char(np_reg[1:0]))
                                  ? np_reg + 3'd1 : NP_BAD;
                    else if (np_reg == NP_FULL)
                        np_next = (c == 8'd0) ? NP_DONE : NP_BAD;
                end
            end
            S_VAL:
            begin
                if (c <= 8'd3 || c == T_IAC)
                begin
                    for (int k = 0; k < 4; k++)
                        if (sub_reg == 8'(k + 1))
                            size_next[k] = 8'd0;
                    state_next   = (c == T_IAC) ? S_IAC : S_VAR;
                    sub_next     = 8'd1;
                    size_next[0] = 8'd0;
                    np_next      = 3'd0;
                    vu_next      = 1'b0;
                    if (vu_reg)
                    begin
                        res_c = 1'b1;
                        ba_c  = ret_code_reg;
                    end
                end
                else if (vu_reg)
                begin
                    res_c = 1'b1;
                    ba_c  = c;
                end
            end
            S_ARG:   state_next = (sub_reg != 8'd0) ? S_IAC : S_DATA;
            default: state_next = S_DATA;
        endcase
    end

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_DATA;
            sub_reg   <= 8'd0;
            np_reg    <= 3'd0;
            vu_reg    <= 1'b0;
            cur_w_reg <= RST_DEF_WIDTH;
            cur_h_reg <= RST_DEF_HEIGHT;
            for (int k = 0; k < 4; k++)
                size_reg[k] <= 8'd0;
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
            sub_reg   <= sub_next;
            np_reg    <= np_next;
            vu_reg    <= vu_next;
            cur_w_reg <= cur_w_next;
            cur_h_reg <= cur_h_next;
            size_reg  <= size_next;
        end
    end

    // result sequencer next values
    always_comb
    begin
        pend_next = pend_reg;
        seq_next  = seq_reg;
        idx_next  = idx_reg;
        ba_next   = ba_reg;
        bb_next   = bb_reg;
        cols_next = cols_reg;
        rows_next = rows_reg;
        if (out_fire)
        begin
            if (out_last)
                pend_next = 1'b0;
            else
                idx_next = idx_reg + 3'd1;
        end
        if (in_fire && res_c)
        begin
            pend_next = 1'b1;
            seq_next  = seq_c;
            idx_next  = 3'd0;
            ba_next   = ba_c;
            bb_next   = bb_c;
            cols_next = cur_w_next;
            rows_next = cur_h_next;
        end
    end

    // sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            seq_reg  <= SEQ_USER;
            idx_reg  <= 3'd0;
        end
        else
        begin
            pend_reg <= pend_next;
            seq_reg  <= seq_next;
            idx_reg  <= idx_next;
        end
    end

    // sequencer payload
    always_ff @(posedge clk)
    begin
        ba_reg   <= ba_next;
        bb_reg   <= bb_next;
        cols_reg <= cols_next;
        rows_reg <= rows_next;
    end

    // result fields for the current sequence position
    always_comb
    begin
        out_ch.valid     = pend_reg;
        out_ch.last      = out_last;
        out_ch.kind      = KIND_PEER;
        out_ch.out_byte  = 8'd0;
        out_ch.term_cols = 16'd0;
        out_ch.term_rows = 16'd0;
        case (seq_reg)
            SEQ_USER:
            begin
                out_ch.kind     = KIND_USER;
                out_ch.out_byte = ba_reg;
            end
            SEQ_REFUSE:
            begin
                case (idx_reg)
                    3'd0:    out_ch.out_byte = T_IAC;
                    3'd1:    out_ch.out_byte = bb_reg;
                    default: out_ch.out_byte = ba_reg;
                endcase
            end
            SEQ_AYT: out_ch.out_byte = ayt_byte(idx_reg);
            SEQ_ENV: out_ch.out_byte = env_byte(idx_reg);
            SEQ_SIZE:
            begin
                out_ch.kind      = KIND_SIZE;
                out_ch.term_cols = cols_reg;
                out_ch.term_rows = rows_reg;
            end
            default: out_ch.out_byte = 8'd0;
        endcase
    end

endmodule

// ===== sv/tnop_checker.sv =====
// tnop_checker: port-level assertions for the telnet option parser
// depends on tnop_pkg; bound to telnet_option_parser_unit
module tnop_checker
    import tnop_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  kind,
    input logic [7:0]  out_byte,
    input logic [15:0] term_cols,
    input logic [15:0] term_rows,
    input logic        last
);

    // a stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // results of one byte come without gaps
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid)
        else $error("gap inside a multi-result transaction");

    // size update is a single result with no byte
    a_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_SIZE |-> last && out_byte == 8'd0)
        else $error("malformed size update");

    // size fields stay zero on byte results
    a_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_SIZE |-> term_cols == 16'd0 && term_rows == 16'd0
            && (kind == KIND_USER || kind == KIND_PEER))
        else $error("bad byte result fields");

endmodule

bind telnet_option_parser_unit tnop_checker u_tnop_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .kind      (out_ch.kind),
    .out_byte  (out_ch.out_byte),
    .term_cols (out_ch.term_cols),
    .term_rows (out_ch.term_rows),
    .last      (out_ch.last)
);
